@@ rtl/htd_pkg.sv @@
package htd_pkg;

  // Default sizes for the node table and the longest codeword
  localparam int NODE_COUNT_DEF    = 512;
  localparam int MAX_CODE_BITS_DEF = 16;

  // Field widths
  localparam int KIND_W   = 2;
  localparam int CODE_W   = 16;
  localparam int CLEN_W   = 5;
  localparam int SYM_W    = 8;
  localparam int STATUS_W = 2;
  localparam int BYTE_W   = 8;

  // Bit counter: holds a saturated code length (up to MAX_CODE_BITS) or a byte's bit count
  localparam int LEN_CNT_W = 6;
  // Valid-bit count of a message's last byte (1..8)
  localparam int LAST_BITS_W = 4;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STREAM = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_PATH = 2'd2;

endpackage

@@ rtl/htd_if.sv @@
interface htd_in_if;
  logic                          valid;
  logic                          ready;
  logic [htd_pkg::KIND_W-1:0]    kind;
  logic [htd_pkg::CODE_W-1:0]    code_bits;
  logic [htd_pkg::CLEN_W-1:0]    code_length;
  logic [htd_pkg::SYM_W-1:0]     code_symbol;
  logic [htd_pkg::BYTE_W-1:0]    stream_byte;
  logic                          final_byte;

  modport source (
    output valid, kind, code_bits, code_length, code_symbol, stream_byte, final_byte,
    input  ready
  );
  modport sink (
    input  valid, kind, code_bits, code_length, code_symbol, stream_byte, final_byte,
    output ready
  );
endinterface

interface htd_out_if;
  logic                          valid;
  logic                          ready;
  logic [htd_pkg::SYM_W-1:0]     out_symbol;
  logic [htd_pkg::STATUS_W-1:0]  status;
  logic                          last_in_run;
  logic                          end_of_message;

  modport source (
    output valid, out_symbol, status, last_in_run, end_of_message,
    input  ready
  );
  modport sink (
    input  valid, out_symbol, status, last_in_run, end_of_message,
    output ready
  );
endinterface

@@ rtl/huffman_tree_bit_decoder_unit.sv @@
// Huffman tree-walk decoder. The code tree lives in a node table (one RAM with a
// registered read port; the root's two child pointers sit in flip-flops, so no
// clearing pass is needed after reset). A clear item gives no result. An insert
// walks the codeword MSB first, each bit taking a node read, or a parent update
// plus a new-node write, and ends with one status result. A stream byte is a
// header (no result) or a data byte: the accept step, a fetch of the current node
// when the walk sits mid-code, a child select for each walked bit and a child
// read for each existing child, a result step for each leaf reached or bad path,
// an end-of-byte step and a flush of any held result. The node table's single
// registered read port paces the walk.
// Each result is held back by one slot so the last one of an item can carry
// last_in_run; a full output register stalls the walk, never the data.
module huffman_tree_bit_decoder_unit #(
  parameter int NODE_COUNT    = htd_pkg::NODE_COUNT_DEF,
  parameter int MAX_CODE_BITS = htd_pkg::MAX_CODE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  htd_in_if.sink    in_ch,
  htd_out_if.source out_ch
);

  localparam int IdxW   = $clog2(NODE_COUNT);
  localparam int UsedW  = $clog2(NODE_COUNT + 1);
  localparam int SymW   = htd_pkg::SYM_W;
  localparam int EntW   = 2 * IdxW + SymW;
  localparam int LenW   = htd_pkg::LEN_CNT_W;
  localparam int LbW    = htd_pkg::LAST_BITS_W;
  localparam int CodeW  = htd_pkg::CODE_W;
  localparam int CSelW  = $clog2(CodeW);
  localparam int ByteW  = htd_pkg::BYTE_W;
  localparam int StW    = htd_pkg::STATUS_W;
  localparam logic [LenW-1:0]  MaxLen    = LenW'(MAX_CODE_BITS);
  localparam logic [LenW-1:0]  CodeBits  = LenW'(CodeW);
  localparam logic [LenW-1:0]  ByteBits  = LenW'(ByteW);
  localparam logic [UsedW-1:0] FullCount = UsedW'(NODE_COUNT);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_STEP,
    S_INS_NEW,
    S_INS_RD,
    S_INS_DONE,
    S_DEC_LD,
    S_DEC_BIT,
    S_DEC_CH,
    S_DEC_RES,
    S_DEC_FLUSH
  } state_t;

  state_t state_r;

  // Tree bookkeeping
  logic [IdxW-1:0]  root_l_r, root_r_r;
  logic [UsedW-1:0] nodes_used_r;
  logic [IdxW-1:0]  walk_pos_r;
  logic             expect_hdr_r;
  logic [LbW-1:0]   last_bits_r;

  // Working node and walk counters
  logic [IdxW-1:0]  pos_r;
  logic [IdxW-1:0]  cur_l_r, cur_r_r;
  logic [SymW-1:0]  cur_sym_r;
  logic [LenW-1:0]  cnt_r;
  logic [CodeW-1:0] code_r;
  logic [SymW-1:0]  ins_sym_r;
  logic [StW-1:0]   ins_st_r;
  logic [ByteW-1:0] byte_r;
  logic             final_r;

  // Fresh result and the one held back for last_in_run
  logic [SymW-1:0]  res_sym_r;
  logic [StW-1:0]   res_st_r;
  logic             pend_vld_r;
  logic [SymW-1:0]  pend_sym_r;
  logic [StW-1:0]   pend_st_r;

  // Output register
  logic             out_vld_r;
  logic [SymW-1:0]  out_sym_r;
  logic [StW-1:0]   out_st_r;
  logic             out_last_r;
  logic             out_eom_r;

  // Node table port
  logic             ram_we, ram_re;
  logic [IdxW-1:0]  ram_waddr, ram_raddr;
  logic [EntW-1:0]  ram_wdata, ram_rdata;

  logic             accept;
  logic             slot_free;
  logic [LenW-1:0]  len_in;
  logic [LenW-1:0]  len_sat;
  logic [LenW-1:0]  ins_idx;
  logic             ins_bit;
  logic             step_bit;
  logic [IdxW-1:0]  child;
  logic             child_none;
  logic             table_full;
  logic [IdxW-1:0]  new_idx;
  logic [IdxW-1:0]  upd_l, upd_r;
  logic [IdxW-1:0]  rd_l, rd_r;
  logic [SymW-1:0]  rd_sym;
  logic             rd_leaf;
  logic [LbW-1:0]   hdr_bits;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_vld_r || out_ch.ready;

  assign out_ch.valid          = out_vld_r;
  assign out_ch.out_symbol     = out_sym_r;
  assign out_ch.status         = out_st_r;
  assign out_ch.last_in_run    = out_last_r;
  assign out_ch.end_of_message = out_eom_r;

  // Saturate the codeword length; bits above the code field read as zero
  assign len_in  = LenW'(in_ch.code_length);
  assign len_sat = (len_in > MaxLen) ? MaxLen : len_in;
  assign ins_idx = cnt_r - LenW'(1);
  assign ins_bit = (ins_idx < CodeBits) ? code_r[ins_idx[CSelW-1:0]] : 1'b0;

  // Shared child-select step for both insert and decode walks
  assign step_bit   = (state_r == S_DEC_BIT) ? byte_r[ByteW-1] : ins_bit;
  assign child      = step_bit ? cur_r_r : cur_l_r;
  assign child_none = (child == '0);
  assign table_full = (nodes_used_r == FullCount);
  assign new_idx    = nodes_used_r[IdxW-1:0];
  assign upd_l      = step_bit ? cur_l_r : new_idx;
  assign upd_r      = step_bit ? new_idx : cur_r_r;

  assign rd_l    = ram_rdata[EntW-1 -: IdxW];
  assign rd_r    = ram_rdata[EntW-IdxW-1 -: IdxW];
  assign rd_sym  = ram_rdata[SymW-1:0];
  assign rd_leaf = (rd_l == '0) && (rd_r == '0);

  // Header: value mod 8, with 0 meaning 8
  assign hdr_bits = (in_ch.stream_byte[2:0] == 3'd0) ? LbW'(ByteW)
                                                     : LbW'(in_ch.stream_byte[2:0]);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos_r;
    ram_wdata = {upd_l, upd_r, cur_sym_r};
    ram_re    = 1'b0;
    ram_raddr = child;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_ch.kind == htd_pkg::KIND_STREAM && !expect_hdr_r
            && walk_pos_r != '0) begin
          ram_re    = 1'b1;
          ram_raddr = walk_pos_r;
        end
      end
      S_INS_STEP: begin
        if (cnt_r != '0) begin
          if (!child_none) begin
            ram_re = 1'b1;
          end else if (!table_full && pos_r != '0) begin
            ram_we = 1'b1;
          end
        end
      end
      S_INS_NEW: begin
        ram_we    = 1'b1;
        ram_waddr = new_idx;
        ram_wdata = {{IdxW{1'b0}}, {IdxW{1'b0}}, ins_sym_r};
      end
      S_DEC_BIT: begin
        if (cnt_r != '0 && !child_none) begin
          ram_re = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  htd_ram #(
    .WIDTH (EntW),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      root_l_r     <= '0;
      root_r_r     <= '0;
      nodes_used_r <= UsedW'(1);
      walk_pos_r   <= '0;
      expect_hdr_r <= 1'b1;
      last_bits_r  <= LbW'(ByteW);
      pend_vld_r   <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      // Drop the output once it has been taken
      if (out_vld_r && out_ch.ready) begin
        out_vld_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_ch.kind == htd_pkg::KIND_CLEAR) begin
              root_l_r     <= '0;
              root_r_r     <= '0;
              nodes_used_r <= UsedW'(1);
              walk_pos_r   <= '0;
            end else if (in_ch.kind == htd_pkg::KIND_INSERT) begin
              pos_r     <= '0;
              cur_l_r   <= root_l_r;
              cur_r_r   <= root_r_r;
              cur_sym_r <= '0;
              cnt_r     <= len_sat;
              code_r    <= in_ch.code_bits;
              ins_sym_r <= in_ch.code_symbol;
              state_r   <= S_INS_STEP;
            end else if (in_ch.kind == htd_pkg::KIND_STREAM) begin
              if (expect_hdr_r) begin
                last_bits_r <= hdr_bits;
                walk_pos_r  <= '0;
                if (!in_ch.final_byte) begin
                  expect_hdr_r <= 1'b0;
                end
              end else begin
                byte_r     <= in_ch.stream_byte;
                final_r    <= in_ch.final_byte;
                cnt_r      <= in_ch.final_byte ? LenW'(last_bits_r) : ByteBits;
                pend_vld_r <= 1'b0;
                if (walk_pos_r == '0) begin
                  cur_l_r <= root_l_r;
                  cur_r_r <= root_r_r;
                  state_r <= S_DEC_BIT;
                end else begin
                  state_r <= S_DEC_LD;
                end
              end
            end
          end
        end

        S_INS_STEP: begin
          if (cnt_r == '0) begin
            ins_st_r <= htd_pkg::STATUS_OK;
            state_r  <= S_INS_DONE;
          end else if (!child_none) begin
            // Follow an existing child; its entry arrives next cycle
            pos_r   <= child;
            cnt_r   <= ins_idx;
            state_r <= S_INS_RD;
          end else if (table_full) begin
            ins_st_r <= htd_pkg::STATUS_FULL;
            state_r  <= S_INS_DONE;
          end else begin
            // Link the new node into its parent (root kept in flops)
            if (pos_r == '0) begin
              root_l_r <= upd_l;
              root_r_r <= upd_r;
            end
            state_r <= S_INS_NEW;
          end
        end

        S_INS_NEW: begin
          pos_r        <= new_idx;
          cur_l_r      <= '0;
          cur_r_r      <= '0;
          cur_sym_r    <= ins_sym_r;
          nodes_used_r <= nodes_used_r + UsedW'(1);
          cnt_r        <= ins_idx;
          state_r      <= S_INS_STEP;
        end

        S_INS_RD: begin
          cur_l_r   <= rd_l;
          cur_r_r   <= rd_r;
          cur_sym_r <= rd_sym;
          state_r   <= S_INS_STEP;
        end

        S_INS_DONE: begin
          if (slot_free) begin
            out_vld_r  <= 1'b1;
            out_sym_r  <= '0;
            out_st_r   <= ins_st_r;
            out_last_r <= 1'b1;
            out_eom_r  <= 1'b0;
            state_r    <= S_IDLE;
          end
        end

        S_DEC_LD: begin
          cur_l_r <= rd_l;
          cur_r_r <= rd_r;
          state_r <= S_DEC_BIT;
        end

        S_DEC_BIT: begin
          if (cnt_r == '0) begin
            // End of byte: a final byte drops any partial code
            if (final_r) begin
              walk_pos_r   <= '0;
              expect_hdr_r <= 1'b1;
            end
            state_r <= pend_vld_r ? S_DEC_FLUSH : S_IDLE;
          end else begin
            byte_r <= {byte_r[ByteW-2:0], 1'b0};
            cnt_r  <= cnt_r - LenW'(1);
            if (child_none) begin
              res_sym_r  <= '0;
              res_st_r   <= htd_pkg::STATUS_BAD_PATH;
              walk_pos_r <= '0;
              cur_l_r    <= root_l_r;
              cur_r_r    <= root_r_r;
              state_r    <= S_DEC_RES;
            end else begin
              walk_pos_r <= child;
              state_r    <= S_DEC_CH;
            end
          end
        end

        S_DEC_CH: begin
          if (rd_leaf) begin
            res_sym_r  <= rd_sym;
            res_st_r   <= htd_pkg::STATUS_OK;
            walk_pos_r <= '0;
            cur_l_r    <= root_l_r;
            cur_r_r    <= root_r_r;
            state_r    <= S_DEC_RES;
          end else begin
            cur_l_r <= rd_l;
            cur_r_r <= rd_r;
            state_r <= S_DEC_BIT;
          end
        end

        S_DEC_RES: begin
          // Advance the held result to the output, hold the fresh one back
          if (!pend_vld_r || slot_free) begin
            if (pend_vld_r) begin
              out_vld_r  <= 1'b1;
              out_sym_r  <= pend_sym_r;
              out_st_r   <= pend_st_r;
              out_last_r <= 1'b0;
              out_eom_r  <= final_r;
            end
            pend_vld_r <= 1'b1;
            pend_sym_r <= res_sym_r;
            pend_st_r  <= res_st_r;
            state_r    <= S_DEC_BIT;
          end
        end

        S_DEC_FLUSH: begin
          if (slot_free) begin
            out_vld_r  <= 1'b1;
            out_sym_r  <= pend_sym_r;
            out_st_r   <= pend_st_r;
            out_last_r <= 1'b1;
            out_eom_r  <= final_r;
            pend_vld_r <= 1'b0;
            state_r    <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/htd_ram.sv @@
module htd_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  localparam int NODES    = htd_pkg::NODE_COUNT_DEF;
  localparam int NODE_W   = $clog2(NODES);
  localparam int MAX_BITS = htd_pkg::MAX_CODE_BITS_DEF;

  typedef logic [htd_pkg::KIND_W-1:0] kind_t;
  typedef logic [htd_pkg::CODE_W-1:0] code_word_t;
  typedef logic [htd_pkg::SYM_W-1:0]  sym_t;
  typedef logic [htd_pkg::BYTE_W-1:0] byte_t;

  // The block ignores this kind; it is sent only as noise.
  localparam kind_t KIND_UNUSED = 2'd3;

  localparam int STIM_ITEMS      = 260;
  localparam int HOLD_OFF_AFTER  = 40;    // results seen before the long receiver hold-off
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int WATCHDOG_LIMIT  = 3000;  // cycles without any transfer
  localparam int DRAIN_CYCLES    = 64;

  typedef struct packed {
    logic [htd_pkg::KIND_W-1:0] kind;
    logic [htd_pkg::CODE_W-1:0] code_bits;
    logic [htd_pkg::CLEN_W-1:0] code_length;
    logic [htd_pkg::SYM_W-1:0]  code_symbol;
    logic [htd_pkg::BYTE_W-1:0] stream_byte;
    logic                       final_byte;
  } stim_t;

  typedef struct packed {
    logic [htd_pkg::SYM_W-1:0]    symbol;
    logic [htd_pkg::STATUS_W-1:0] status;
    logic                         last;
    logic                         eom;
  } decoded_t;

  typedef struct packed {
    logic [NODE_W-1:0]         left;
    logic [NODE_W-1:0]         right;
    logic [htd_pkg::SYM_W-1:0] symbol;
  } tree_node_t;

  logic clk;
  logic rst_n;

  htd_in_if  in_ch ();
  htd_out_if out_ch ();

  huffman_tree_bit_decoder_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Tree model: our own copy of the node table and the message state.
  // ---------------------------------------------------------------------------
  tree_node_t                        tree_model [NODES];
  int unsigned                       model_nodes;
  logic [NODE_W-1:0]                 model_walk;
  bit                                model_wants_header;
  logic [htd_pkg::LAST_BITS_W-1:0]   model_tail_bits;

  decoded_t expected_symbols [$];
  stim_t    pending_items [$];

  // Drop the whole tree back to a lone root; message framing is left alone.
  function automatic void clear_model();
    tree_model[0] = '0;
    model_nodes   = 1;
    model_walk    = '0;
  endfunction

  // Work out every result one accepted transfer causes and queue them in order.
  function automatic void decode_step(input stim_t it);
    decoded_t                     run [$];
    decoded_t                     r;
    int unsigned                  len;
    int unsigned                  nbits;
    logic [NODE_W-1:0]            pos;
    logic [NODE_W-1:0]            child;
    logic [htd_pkg::STATUS_W-1:0] st;
    bit                           b;
    bit                           stop;
    case (it.kind)
      htd_pkg::KIND_CLEAR: begin
        clear_model();
      end
      htd_pkg::KIND_INSERT: begin
        // Saturate the length, then walk MSB first, growing missing children.
        len  = (it.code_length > MAX_BITS) ? MAX_BITS : it.code_length;
        pos  = '0;
        st   = htd_pkg::STATUS_OK;
        stop = 1'b0;
        for (int i = len; i > 0 && !stop; i--) begin
          b     = (i - 1 < htd_pkg::CODE_W) ? it.code_bits[i-1] : 1'b0;
          child = b ? tree_model[pos].right : tree_model[pos].left;
          if (child == '0) begin
            if (model_nodes >= NODES) begin
              // Table full: keep what was built so far and stop here.
              st   = htd_pkg::STATUS_FULL;
              stop = 1'b1;
            end else begin
              child = model_nodes[NODE_W-1:0];
              tree_model[child] = '{left: '0, right: '0, symbol: it.code_symbol};
              if (b) tree_model[pos].right = child;
              else   tree_model[pos].left  = child;
              model_nodes++;
            end
          end
          pos = child;
        end
        run.insert(run.size(), decoded_t'{symbol: '0, status: st, last: 1'b0, eom: 1'b0});
      end
      htd_pkg::KIND_STREAM: begin
        if (model_wants_header) begin
          // Header: low three bits give the valid bits of the last byte, 0 means 8.
          model_tail_bits = (it.stream_byte[2:0] == 3'd0) ? 4'd8 : {1'b0, it.stream_byte[2:0]};
          if (!it.final_byte) model_wants_header = 1'b0;
          model_walk = '0;
        end else begin
          nbits = it.final_byte ? model_tail_bits : 8;
          for (int i = 0; i < nbits; i++) begin
            b     = it.stream_byte[7 - i];
            child = b ? tree_model[model_walk].right : tree_model[model_walk].left;
            if (child == '0) begin
              run.insert(run.size(), decoded_t'{symbol: '0, status: htd_pkg::STATUS_BAD_PATH,
                                                last: 1'b0, eom: it.final_byte});
              model_walk = '0;
            end else if (tree_model[child].left == '0 && tree_model[child].right == '0) begin
              run.insert(run.size(), decoded_t'{symbol: tree_model[child].symbol,
                                                status: htd_pkg::STATUS_OK, last: 1'b0,
                                                eom: it.final_byte});
              model_walk = '0;
            end else begin
              model_walk = child;
            end
          end
          // End of message: drop any partial code and wait for a header again.
          if (it.final_byte) begin
            model_walk         = '0;
            model_wants_header = 1'b1;
          end
        end
      end
      default: ;
    endcase
    foreach (run[k]) begin
      r      = run[k];
      r.last = (k == run.size() - 1);
      expected_symbols.insert(expected_symbols.size(), r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  code_word_t cb_bits [$];
  int         cb_len [$];
  sym_t       cb_sym [$];
  bit         msg_open;      // a stream message was started and not yet closed
  int         items_queued;  // items that do something; ignored kinds do not count

  function automatic void push_item(input kind_t       kind,
                                    input logic [31:0] bits,
                                    input logic [31:0] len,
                                    input logic [31:0] sym,
                                    input logic [31:0] sbyte,
                                    input logic        fin);
    stim_t it;
    it.kind        = kind;
    it.code_bits   = bits[htd_pkg::CODE_W-1:0];
    it.code_length = len[htd_pkg::CLEN_W-1:0];
    it.code_symbol = sym[htd_pkg::SYM_W-1:0];
    it.stream_byte = sbyte[htd_pkg::BYTE_W-1:0];
    it.final_byte  = fin;
    pending_items.insert(pending_items.size(), it);
    if (kind != KIND_UNUSED) items_queued++;
    // Track framing so well-formed messages always start on a header.
    if (kind == htd_pkg::KIND_STREAM) begin
      if (!msg_open) msg_open = !fin;
      else if (fin)  msg_open = 1'b0;
    end
  endfunction

  function automatic void close_open_message();
    if (msg_open) push_item(htd_pkg::KIND_STREAM, $urandom, $urandom, $urandom, $urandom, 1'b1);
  endfunction

  function automatic void push_noise_message(input int nbytes);
    close_open_message();
    push_item(htd_pkg::KIND_STREAM, $urandom, $urandom, $urandom, $urandom, 1'b0);
    for (int y = 0; y < nbytes; y++)
      push_item(htd_pkg::KIND_STREAM, $urandom, $urandom, $urandom, $urandom, y == nbytes - 1);
  endfunction

  // Mostly short gaps, a few long ones; none at all while calm.
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm)   return 0;
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present the next pending item at the falling edge.
  // ---------------------------------------------------------------------------
  bit    in_took;
  int    send_gap;
  bit    send_calm;
  stim_t on_wire;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_took) begin
      if (send_gap > 0) begin
        in_ch.valid <= 1'b0;
        send_gap--;
      end else if (pending_items.size() > 0) begin
        on_wire = pending_items.pop_front();
        in_ch.kind        <= on_wire.kind;
        in_ch.code_bits   <= on_wire.code_bits;
        in_ch.code_length <= on_wire.code_length;
        in_ch.code_symbol <= on_wire.code_symbol;
        in_ch.stream_byte <= on_wire.stream_byte;
        in_ch.final_byte  <= on_wire.final_byte;
        in_ch.valid       <= 1'b1;
        if ($urandom_range(0, 31) == 0) send_calm = !send_calm;
        send_gap = pick_gap(send_calm);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, plus one long hold-off so the block fills.
  // ---------------------------------------------------------------------------
  int results_seen;
  int stall_left;
  int hold_left;
  bit hold_done;
  bit recv_calm;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (!hold_done && results_seen >= HOLD_OFF_AFTER) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_done = 1'b1;
      end
      if ($urandom_range(0, 49) == 0) recv_calm = !recv_calm;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!recv_calm && $urandom_range(0, 99) < 25) begin
        stall_left = pick_gap(1'b0);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge, predict and check.
  // ---------------------------------------------------------------------------
  int       transfers_in;
  int       quiet_cycles;
  int       error_count;
  decoded_t got;
  decoded_t want;

  task automatic log_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  always @(posedge clk) begin
    in_took = 1'b0;
    if (rst_n) begin
      // Check outputs before predicting, so a stray result never meets an
      // expectation from the transfer accepted at this same edge.
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        got = '{symbol: out_ch.out_symbol, status: out_ch.status,
                last: out_ch.last_in_run, eom: out_ch.end_of_message};
        if (expected_symbols.size() == 0) begin
          log_mismatch($sformatf("unexpected result sym=%02h st=%0d last=%0b eom=%0b",
                                 got.symbol, got.status, got.last, got.eom));
        end else begin
          want = expected_symbols.pop_front();
          if (got.symbol !== want.symbol || got.status !== want.status ||
              got.last !== want.last || got.eom !== want.eom)
            log_mismatch($sformatf(
              "result %0d: got sym=%02h st=%0d last=%0b eom=%0b, want sym=%02h st=%0d last=%0b eom=%0b",
              results_seen, got.symbol, got.status, got.last, got.eom,
              want.symbol, want.status, want.last, want.eom));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        in_took = 1'b1;
        transfers_in++;
        decode_step('{kind: in_ch.kind, code_bits: in_ch.code_bits,
                      code_length: in_ch.code_length, code_symbol: in_ch.code_symbol,
                      stream_byte: in_ch.stream_byte, final_byte: in_ch.final_byte});
      end
      // Watchdog: any transfer on either side counts as progress.
      if (in_took || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 quiet_cycles, expected_symbols.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and run control
  // ---------------------------------------------------------------------------
  int total_items;

  initial begin
    int         r, k, j, leaves, max_len, skip, nsym, nbits, nbytes, tail;
    int         order [$];
    bit         msg_bits [$];
    code_word_t code;
    code_word_t noise16;
    byte_t      hdr;
    byte_t      sb;
    bit         filled;

    clk                = 1'b0;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.kind         = '0;
    in_ch.code_bits    = '0;
    in_ch.code_length  = '0;
    in_ch.code_symbol  = '0;
    in_ch.stream_byte  = '0;
    in_ch.final_byte   = 1'b0;
    out_ch.ready       = 1'b0;
    clear_model();
    model_wants_header = 1'b1;
    model_tail_bits    = 4'd8;
    filled             = 1'b0;

    // Directed: decode on a bare root (every bit a bad path, eight per byte).
    push_item(htd_pkg::KIND_STREAM, '0, '0, '0, 'h00, 1'b0);
    push_item(htd_pkg::KIND_STREAM, '0, '0, '0, 'hFF, 1'b0);
    push_item(htd_pkg::KIND_STREAM, '0, '0, '0, 'h00, 1'b1);
    // Header that is also the final byte: empty message.
    push_item(htd_pkg::KIND_STREAM, '0, '0, '0, 'hFF, 1'b1);
    // Zero length, full length, and lengths past the limit.
    push_item(htd_pkg::KIND_INSERT, 'hFFFF, 0,  'hFF, '0, 1'b0);
    push_item(htd_pkg::KIND_INSERT, 'hFFFF, 16, 'hFF, '1, 1'b1);
    push_item(htd_pkg::KIND_INSERT, 'h0000, 16, 'h00, '0, 1'b0);
    push_item(htd_pkg::KIND_INSERT, 'hAAAA, 31, 'h5A, '0, 1'b0);
    push_item(htd_pkg::KIND_INSERT, 'h5555, 17, 'hA5, '0, 1'b0);
    push_item(KIND_UNUSED, '1, '1, '1, '1, 1'b1);
    // One valid bit in the last byte; the deep all-ones leaf spans two bytes.
    push_item(htd_pkg::KIND_STREAM, '0, '0, '0, 'hF9, 1'b0);
    push_item(htd_pkg::KIND_STREAM, '0, '0, '0, 'hFF, 1'b0);
    push_item(htd_pkg::KIND_STREAM, '0, '0, '0, 'hFF, 1'b0);
    push_item(htd_pkg::KIND_STREAM, '0, '0, '0, 'h7F, 1'b1);
    // Small complete code: 0, 10, 11.
    push_item(htd_pkg::KIND_CLEAR, '1, '1, '1, '1, 1'b1);
    push_item(htd_pkg::KIND_INSERT, 'h0000, 1, 'h41, '0, 1'b0);
    push_item(htd_pkg::KIND_INSERT, 'h0002, 2, 'h42, '0, 1'b0);
    push_item(htd_pkg::KIND_INSERT, 'h0003, 2, 'h43, '0, 1'b0);
    push_item(htd_pkg::KIND_STREAM, '0, '0, '0, 'h00, 1'b0);
    push_item(htd_pkg::KIND_STREAM, '0, '0, '0, 'h00, 1'b0);
    push_item(htd_pkg::KIND_STREAM, '0, '0, '0, 'hB6, 1'b1);
    // Clear in the middle of a message: framing survives, the tree does not.
    push_item(htd_pkg::KIND_STREAM, '0, '0, '0, 'h03, 1'b0);
    push_item(htd_pkg::KIND_CLEAR, '0, '0, '0, '0, 1'b0);
    push_item(htd_pkg::KIND_STREAM, '0, '0, '0, 'hFF, 1'b1);

    // Random part: mostly codebooks and messages encoded with them.
    while (items_queued < STIM_ITEMS) begin
      r = $urandom_range(0, 99);

      // Once along the way, overfill the table with deep random codewords.
      if (!filled && items_queued > 100) begin
        filled = 1'b1;
        push_item(htd_pkg::KIND_CLEAR, $urandom, $urandom, $urandom, $urandom, 1'($urandom));
        repeat (48)
          push_item(htd_pkg::KIND_INSERT, $urandom,
                    ($urandom_range(0, 5) == 0) ? $urandom_range(17, 31) : 16,
                    $urandom, $urandom, 1'($urandom));
        push_noise_message($urandom_range(2, 4));
        push_item(htd_pkg::KIND_CLEAR, $urandom, $urandom, $urandom, $urandom, 1'($urandom));
        cb_bits.delete();
        cb_len.delete();
        cb_sym.delete();
      end

      if (r < 35 || cb_len.size() == 0) begin
        // Grow a random complete prefix code by splitting leaves.
        leaves  = $urandom_range(2, 12);
        max_len = $urandom_range(4, 12);
        cb_bits = '{16'h0000};
        cb_len  = '{0};
        while (cb_len.size() < leaves) begin
          k = $urandom_range(0, cb_len.size() - 1);
          if (cb_len[k] < max_len) begin
            code = cb_bits[k];
            j    = cb_len[k];
            cb_bits.delete(k);
            cb_len.delete(k);
            cb_bits.insert(cb_bits.size(), {code[htd_pkg::CODE_W-2:0], 1'b0});
            cb_len.insert(cb_len.size(), j + 1);
            cb_bits.insert(cb_bits.size(), {code[htd_pkg::CODE_W-2:0], 1'b1});
            cb_len.insert(cb_len.size(), j + 1);
          end
        end
        cb_sym.delete();
        foreach (cb_len[i]) cb_sym.insert(cb_sym.size(), sym_t'($urandom));
        // Sometimes leave one leaf out so its path decodes as missing.
        skip = ($urandom_range(0, 3) == 0) ? $urandom_range(0, cb_len.size() - 1) : -1;
        order.delete();
        foreach (cb_len[i]) order.insert(order.size(), i);
        push_item(htd_pkg::KIND_CLEAR, $urandom, $urandom, $urandom, $urandom, 1'($urandom));
        while (order.size() > 0) begin
          k = $urandom_range(0, order.size() - 1);
          j = order[k];
          order.delete(k);
          noise16 = code_word_t'($urandom);
          if (j != skip)
            push_item(htd_pkg::KIND_INSERT, (noise16 << cb_len[j]) | cb_bits[j], cb_len[j],
                      cb_sym[j], $urandom, 1'($urandom));
        end
      end

      if (r < 75) begin
        // Well-formed messages from the current code, random content.
        repeat ($urandom_range(1, 3)) begin
          msg_bits.delete();
          nsym = $urandom_range(0, 10);
          repeat (nsym) begin
            j = $urandom_range(0, cb_len.size() - 1);
            for (int p = cb_len[j] - 1; p >= 0; p--)
              msg_bits.insert(msg_bits.size(), cb_bits[j][p]);
          end
          // A trailing partial code must be dropped at the end of the message.
          if ($urandom_range(0, 2) == 0) begin
            j = $urandom_range(0, cb_len.size() - 1);
            for (int p = cb_len[j] - 1; p >= 1; p--)
              msg_bits.insert(msg_bits.size(), cb_bits[j][p]);
          end
          while (msg_bits.size() > 48) msg_bits.delete(msg_bits.size() - 1);
          nbits = msg_bits.size();
          close_open_message();
          if (nbits == 0) begin
            push_item(htd_pkg::KIND_STREAM, $urandom, $urandom, $urandom, $urandom, 1'b1);
          end else begin
            nbytes   = (nbits + 7) / 8;
            tail     = nbits - 8 * (nbytes - 1);
            hdr      = byte_t'($urandom);
            hdr[2:0] = tail[2:0];
            push_item(htd_pkg::KIND_STREAM, $urandom, $urandom, $urandom, hdr, 1'b0);
            for (int y = 0; y < nbytes; y++) begin
              sb = byte_t'($urandom);
              for (int p = 0; p < 8; p++)
                if (y * 8 + p < nbits) sb[7 - p] = msg_bits[y * 8 + p];
              push_item(htd_pkg::KIND_STREAM, $urandom, $urandom, $urandom, sb,
                        y == nbytes - 1);
            end
          end
        end
      end else if (r < 88) begin
        push_noise_message($urandom_range(1, 4));
      end else begin
        // Loose items of any kind, including lengths outside the usual range.
        repeat ($urandom_range(1, 4))
          push_item(kind_t'($urandom_range(0, 3)), $urandom, $urandom_range(0, 31), $urandom,
                    $urandom, 1'($urandom_range(0, 1)));
      end
    end
    total_items = pending_items.size();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for every transfer in, every result out, then let the block settle.
    while (transfers_in < total_items) @(posedge clk);
    while (expected_symbols.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (error_count == 0 && expected_symbols.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
